FILE: sv/sps_pkg.sv
// shared types and constants for the servo pulse sequencer
package sps_pkg;

    localparam int WIDTH_W     = 16;
    localparam int LOAD_INPUTS = 4;
    localparam int PIN_OUT_W   = 4;
    localparam int SLOT_OUT_W  = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int IN_DATA_W   = LOAD_INPUTS * WIDTH_W;
    localparam int OUT_DATA_W  = 8;

    localparam int CHANNELS_DEF = 4;
    localparam int NEUTRAL_DEF  = 3000;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd2000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd4000;
    localparam logic [WIDTH_W-1:0] MAX_PULSE       = 16'd8000;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_WIDTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_WIDTH = 1'd1;

    typedef enum logic [1:0] {
        OP_SLOT  = 2'd0,
        OP_TIMER = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                                opcode;
        logic [LOAD_INPUTS-1:0][WIDTH_W-1:0]    widths;
    } item_t;

    typedef struct packed {
        logic                   pulse_busy;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [PIN_OUT_W-1:0]   pin_levels;
    } result_t;

endpackage

FILE: sv/servo_pulse_sequencer.sv
// servo pulse sequencer top level
// Takes one item per clock while m_tready allows: a transfer lands in the input register,
// then the slot rotation, pulse countdown and width buffers are updated and the result
// register is written, and the result is offered on m_tvalid from the result register;
// items can stream back to back without gaps while m_tready is high. Opcode 0
// advances the slot rotation (channel slots, then the fetch slot that copies pending
// widths into the active set), opcode 1 is a pulse timer tick, opcode 2 loads clamped
// widths into the pending buffer, opcode 3 leaves the state unchanged. Each item gives
// exactly one result; stalling m_tready holds the pipeline with nothing lost. Write
// min_width (index 0) and max_width (index 1) only while the block is idle.
module servo_pulse_sequencer #(
    parameter int CHANNELS = sps_pkg::CHANNELS_DEF,
    parameter int NEUTRAL  = sps_pkg::NEUTRAL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sps_pkg::WIDTH_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [1:0]                      s_tuser,    // opcode
    input  logic [sps_pkg::IN_DATA_W-1:0]   s_tdata,    // width_0, width_1, width_2, width_3
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sps_pkg::OUT_DATA_W-1:0]  m_tdata     // pin_levels, slot, pulse_busy
);
    import sps_pkg::*;

    item_t   item;
    result_t result_next;
    logic    item_valid;
    logic    out_free;
    logic    advance;

    assign advance = item_valid && out_free;

    sps_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sps_core #(
        .CHANNELS (CHANNELS),
        .NEUTRAL  (NEUTRAL)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .advance     (advance),
        .item        (item),
        .result_next (result_next)
    );

    sps_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result_next),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sv/sps_in_reg.sv
// input register stage of the servo pulse sequencer
module sps_in_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_tuser,
    input  logic [sps_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                       take,
    output logic                       item_valid,
    output sps_pkg::item_t             item
);
    import sps_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode <= opcode_t'(s_tuser);
            item_reg.widths <= s_tdata;
        end
    end

endmodule

FILE: sv/sps_core.sv
// sequencer state and the per-item update logic
module sps_core #(
    parameter int CHANNELS = sps_pkg::CHANNELS_DEF,
    parameter int NEUTRAL  = sps_pkg::NEUTRAL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sps_pkg::WIDTH_W-1:0]     cfg_wdata,
    input  logic                            advance,
    input  sps_pkg::item_t                  item,
    output sps_pkg::result_t                result_next
);
    import sps_pkg::*;

    localparam int SLOT_W     = $clog2(CHANNELS + 1);
    localparam int SLOT_EXT_W = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
    localparam int PIN_EXT_W  = (CHANNELS > PIN_OUT_W) ? CHANNELS : PIN_OUT_W;
    localparam int N_LOAD     = (CHANNELS < LOAD_INPUTS) ? CHANNELS : LOAD_INPUTS;
    localparam logic [SLOT_W-1:0]  FETCH_SLOT    = SLOT_W'(CHANNELS);
    localparam logic [WIDTH_W-1:0] NEUTRAL_WIDTH = WIDTH_W'(NEUTRAL);

    logic [WIDTH_W-1:0]  min_reg;
    logic [WIDTH_W-1:0]  max_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [WIDTH_W-1:0]  active_reg   [CHANNELS];
    logic [WIDTH_W-1:0]  active_next  [CHANNELS];
    logic [WIDTH_W-1:0]  pending_reg  [CHANNELS];
    logic [WIDTH_W-1:0]  pending_next [CHANNELS];
    logic [WIDTH_W-1:0]  count_reg;
    logic [WIDTH_W-1:0]  count_next;
    logic                running_reg;
    logic                running_next;
    logic [CHANNELS-1:0] pin_reg;
    logic [CHANNELS-1:0] pin_next;

    logic [SLOT_W-1:0]     slot_adv;
    logic [WIDTH_W-1:0]    sel_width;
    logic [WIDTH_W-1:0]    start_width;
    logic [WIDTH_W-1:0]    count_dec;
    logic [PIN_EXT_W-1:0]  pin_ext;
    logic [SLOT_EXT_W-1:0] slot_ext;

    // below min wins over above max
    function automatic logic [WIDTH_W-1:0] clamp_width(
        input logic [WIDTH_W-1:0] v,
        input logic [WIDTH_W-1:0] lo,
        input logic [WIDTH_W-1:0] hi
    );
        logic [WIDTH_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        slot_adv = (slot_reg >= FETCH_SLOT) ? '0 : slot_reg + SLOT_W'(1);

        sel_width = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (slot_adv == SLOT_W'(i)) begin
                sel_width = active_reg[i];
            end
        end
        start_width = (sel_width > MAX_PULSE) ? MAX_PULSE : sel_width;
        count_dec   = (count_reg != '0) ? count_reg - WIDTH_W'(1) : count_reg;

        slot_next    = slot_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        running_next = running_reg;
        pin_next     = pin_reg;

        if (advance) begin
            case (item.opcode)
                OP_SLOT: begin
                    // every slot tick ends whatever pulse is still out
                    pin_next     = '0;
                    count_next   = '0;
                    running_next = 1'b0;
                    slot_next    = slot_adv;
                    if (slot_adv == FETCH_SLOT) begin
                        active_next = pending_reg;
                    end else if (start_width != '0) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            pin_next[i] = (slot_adv == SLOT_W'(i));
                        end
                        count_next   = start_width;
                        running_next = 1'b1;
                    end
                end
                OP_TIMER: begin
                    if (running_reg) begin
                        count_next = count_dec;
                        if (count_dec == '0) begin
                            pin_next     = '0;
                            running_next = 1'b0;
                        end
                    end
                end
                OP_LOAD: begin
                    for (int i = 0; i < N_LOAD; i++) begin
                        pending_next[i] = clamp_width(item.widths[i], min_reg, max_reg);
                    end
                end
                default: begin
                end
            endcase
        end

        pin_ext  = PIN_EXT_W'(pin_next);
        slot_ext = SLOT_EXT_W'(slot_next);
        result_next.pin_levels = pin_ext[PIN_OUT_W-1:0];
        result_next.slot       = slot_ext[SLOT_OUT_W-1:0];
        result_next.pulse_busy = running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= MIN_WIDTH_RESET;
            max_reg     <= MAX_WIDTH_RESET;
            slot_reg    <= FETCH_SLOT;
            count_reg   <= '0;
            running_reg <= 1'b0;
            pin_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                active_reg[i]  <= NEUTRAL_WIDTH;
                pending_reg[i] <= NEUTRAL_WIDTH;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MIN_WIDTH: min_reg <= cfg_wdata;
                    REG_MAX_WIDTH: max_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            slot_reg    <= slot_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            pin_reg     <= pin_next;
        end
    end

    a_pin_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pin_reg))
        else $error("more than one servo pin high");

    a_pin_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (pin_reg != '0) == running_reg)
        else $error("pin level and pulse countdown disagree");

    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (count_reg != '0))
        else $error("countdown running at zero");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= FETCH_SLOT)
        else $error("slot index past fetch slot");

    a_pulse_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.opcode == OP_TIMER && running_reg && count_reg == WIDTH_W'(1))
        |=> !running_reg)
        else $error("pulse did not end on last timer tick");

endmodule

FILE: sv/sps_out_reg.sv
// result register of the servo pulse sequencer
module sps_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  sps_pkg::result_t                result,
    output logic                            free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sps_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import sps_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.pulse_busy, result_reg.slot, result_reg.pin_levels};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule
